// ===== hw/rtl/seg_pkg.sv =====
// Shared types, codes and segment table for the seven-segment scan driver.
// No dependencies; seg_front, seg_back, the top level and the testbench files import this package.
`default_nettype none

package seg_pkg;

	// Item function codes
	localparam logic FUNC_SET  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Queue entry kind, held in bit 0 of an entry
	localparam logic ENTRY_KIND_TICK = 1'b0;
	localparam logic ENTRY_KIND_SET  = 1'b1;

	// Segment pattern geometry
	localparam int         SEG_BITS  = 8;
	localparam logic [7:0] POINT_BIT = 8'h01;

	// Divide by ten: quotient = (v * MAGIC) >> SHIFT, exact for 32-bit v
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;

	// Front sequencer states
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MUL  = 3'b010,
		F_DIG  = 3'b100
	} front_state_t;

	// Input item
	typedef struct packed {
		logic        func;
		logic [31:0] scaled_value;
		logic [2:0]  decimals;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic       serial_data;
		logic       shift_pulse;
		logic       latch_pulse;
		logic [3:0] digit_enables;
		logic       last;
	} out_item_t;

	// Map a decimal digit to its segment pattern (point bit clear)
	function automatic logic [7:0] seg_pattern(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'hFC;
			4'd1: p = 8'h60;
			4'd2: p = 8'hDA;
			4'd3: p = 8'hF2;
			4'd4: p = 8'h66;
			4'd5: p = 8'hB6;
			4'd6: p = 8'hBE;
			4'd7: p = 8'hE0;
			4'd8: p = 8'hFE;
			4'd9: p = 8'hF6;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/seg_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Standalone; payload types come from seg_pkg or the instantiating module.
`default_nettype none

interface seg_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/seg_front.sv =====
// Front end: accepts items, turns a set value into segment patterns with a
// shared divide-by-ten unit, and pushes set and tick commands to the queue. Uses seg_pkg.
`default_nettype none

module seg_front import seg_pkg::*; #(
	parameter int DIGIT_COUNT = 4,
	localparam int ENTRY_W = SEG_BITS * DIGIT_COUNT + 1,
	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	seg_stream_if.sink    req,
	seg_stream_if.source  cmd
);

	localparam int Q_W = 64 - DIV10_SHIFT;

	front_state_t     state_q;
	logic [31:0]      val_q;
	logic [63:0]      prod_s1;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       dec_q;
	logic [7:0]       pats_q [DIGIT_COUNT];

	logic             accept;
	logic [63:0]      prod;
	logic [Q_W-1:0]   quot;
	logic [31:0]      rem_full;
	logic             point;
	logic [7:0]       digit_pat;
	logic             last_step;
	logic [ENTRY_W-2:0] set_flat;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == F_IDLE) && cmd.ready;

	// Reciprocal multiply, then quotient and remainder of one digit
	assign prod = 64'(val_q) * 64'(DIV10_MAGIC);
	assign quot = prod_s1[63:DIV10_SHIFT];
	assign rem_full = val_q - (32'({quot, 3'b000}) + 32'({quot, 1'b0}));
	assign point = (dec_q != 3'd0) && ({29'd0, dec_q} == 32'(idx_q));
	assign digit_pat = seg_pattern(rem_full[3:0]) | (point ? POINT_BIT : 8'h00);
	assign last_step = (idx_q == IDX_W'(DIGIT_COUNT - 1));

	// Assemble the finished pattern set, digit 0 in the low byte
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
			set_flat[SEG_BITS*i +: SEG_BITS] = pats_q[i+1];
		end
		set_flat[SEG_BITS*(DIGIT_COUNT-1) +: SEG_BITS] = digit_pat;
	end

	// Push ticks at once, sets when the last digit is done
	always_comb begin
		cmd.valid = 1'b0;
		cmd.data = {(ENTRY_W-1)'(0), ENTRY_KIND_TICK};
		if (state_q == F_DIG) begin
			cmd.valid = last_step;
			cmd.data = {set_flat, ENTRY_KIND_SET};
		end else if (state_q == F_IDLE) begin
			cmd.valid = accept && (req.data.func == FUNC_TICK);
		end
	end

	// Sequence the digit unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && (req.data.func == FUNC_SET)) begin
						state_q <= F_MUL;
						idx_q <= '0;
					end
				end
				F_MUL: state_q <= F_DIG;
				F_DIG: begin
					idx_q <= idx_q + IDX_W'(1);
					state_q <= last_step ? F_IDLE : F_MUL;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Hold the working value, product and partial patterns
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			val_q <= req.data.scaled_value;
			dec_q <= req.data.decimals;
		end
		if (state_q == F_MUL) begin
			prod_s1 <= prod;
		end
		if (state_q == F_DIG) begin
			val_q <= 32'(quot);
			for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
				pats_q[i] <= pats_q[i+1];
			end
			pats_q[DIGIT_COUNT-1] <= digit_pat;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/seg_queue.sv =====
// Two-entry queue between front and back end.
// Uses seg_stream_if; payload width set by parameter.
`default_nettype none

module seg_queue #(
	parameter int WIDTH = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	seg_stream_if.sink    push,
	seg_stream_if.source  pop
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push.ready = (cnt_q != 2'd2);
	assign pop.valid = (cnt_q != 2'd0);
	assign pop.data = mem_q[rd_q];
	assign do_push = push.valid && push.ready;
	assign do_pop = pop.valid && pop.ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Write entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push.data;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/seg_back.sv =====
// Back end: holds the segment store and scan state, and plays each tick
// out as shift, latch and enable results through an output register. Uses seg_pkg.
`default_nettype none

module seg_back import seg_pkg::*; #(
	parameter int DIGIT_COUNT = 4,
	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1,
	localparam int MW = (DIGIT_COUNT > 4) ? DIGIT_COUNT : 4
) (
	input  logic          clk,
	input  logic          arst_n,
	seg_stream_if.sink    cmd,
	seg_stream_if.source  rsp
);

	logic [7:0]             store_q [DIGIT_COUNT];
	logic                   valid_q;
	logic [POS_W-1:0]       scan_q;
	logic [POS_W-1:0]       prior_q;
	logic                   has_prior_q;
	logic [DIGIT_COUNT-1:0] mask_q;
	logic [DIGIT_COUNT-1:0] nmask_q;
	logic                   active_q;
	logic [3:0]             cnt_q;
	logic [7:0]             pat_q;
	logic                   ov_q;
	out_item_t              obuf_q;

	logic                   can_load;
	logic                   pop;
	logic                   is_set;
	logic [DIGIT_COUNT-1:0] set_mask;
	logic [DIGIT_COUNT-1:0] next_mask;
	logic [MW-1:0]          old_ext;
	logic [MW-1:0]          next_ext;
	logic [MW-1:0]          nmask_ext;

	assign can_load = !ov_q || rsp.ready;
	assign cmd.ready = !active_q && can_load;
	assign pop = cmd.valid && cmd.ready;
	assign is_set = (cmd.data[0] == ENTRY_KIND_SET);
	assign rsp.valid = ov_q;
	assign rsp.data = obuf_q;

	// Turn on the current digit if patterns exist, drop the previous one
	always_comb begin
		set_mask = valid_q ? (mask_q | (DIGIT_COUNT'(1) << scan_q)) : mask_q;
		next_mask = set_mask;
		if (has_prior_q && (prior_q != scan_q)) begin
			next_mask = set_mask & ~(DIGIT_COUNT'(1) << prior_q);
		end
	end

	assign old_ext = MW'(mask_q);
	assign next_ext = MW'(next_mask);
	assign nmask_ext = MW'(nmask_q);

	// Control state: scan position, enables, run counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			scan_q <= '0;
			prior_q <= '0;
			has_prior_q <= 1'b0;
			mask_q <= '0;
			active_q <= 1'b0;
			cnt_q <= 4'd0;
			ov_q <= 1'b0;
		end else if (can_load) begin
			ov_q <= active_q || (pop && !is_set);
			if (active_q) begin
				if (cnt_q == 4'(SEG_BITS)) begin
					active_q <= 1'b0;
					mask_q <= nmask_q;
				end else begin
					cnt_q <= cnt_q + 4'd1;
				end
			end else if (pop) begin
				if (is_set) begin
					valid_q <= 1'b1;
				end else begin
					prior_q <= scan_q;
					has_prior_q <= 1'b1;
					scan_q <= (scan_q == POS_W'(DIGIT_COUNT - 1)) ? '0
						: scan_q + POS_W'(1);
					if (valid_q) begin
						active_q <= 1'b1;
						cnt_q <= 4'd1;
					end else begin
						mask_q <= next_mask;
					end
				end
			end
		end
	end

	// Payload: segment store, current pattern, result register
	always_ff @(posedge clk) begin
		if (can_load) begin
			if (active_q) begin
				if (cnt_q == 4'(SEG_BITS)) begin
					obuf_q <= '{serial_data: 1'b0, shift_pulse: 1'b0, latch_pulse: 1'b1,
						digit_enables: nmask_ext[3:0], last: 1'b1};
				end else begin
					obuf_q <= '{serial_data: pat_q[cnt_q[2:0]], shift_pulse: 1'b1,
						latch_pulse: 1'b0, digit_enables: old_ext[3:0], last: 1'b0};
				end
			end else if (pop) begin
				if (is_set) begin
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						store_q[i] <= cmd.data[1 + SEG_BITS*i +: SEG_BITS];
					end
				end else if (valid_q) begin
					pat_q <= store_q[scan_q];
					nmask_q <= next_mask;
					obuf_q <= '{serial_data: store_q[scan_q][0], shift_pulse: 1'b1,
						latch_pulse: 1'b0, digit_enables: old_ext[3:0], last: 1'b0};
				end else begin
					obuf_q <= '{serial_data: 1'b0, shift_pulse: 1'b0, latch_pulse: 1'b0,
						digit_enables: next_ext[3:0], last: 1'b1};
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/seven_segment_scan_driver.sv =====
// Top level of the seven-segment scan driver: front end, command queue, back end.
// Uses seg_pkg, seg_stream_if, seg_front, seg_queue and seg_back.
//
//   channel  dir  payload     carries
//   req      in   in_item_t   set value or scan tick
//   rsp      out  out_item_t  shift bit, latch pulse and digit enables
//
// A tick with patterns present yields nine results, one per cycle while rsp
// is ready, paced by the back end's bit counter; a blank tick yields one.
// A set holds the front end from acceptance until its last digit is done, one digit per
// multiply and subtract pair, and overlaps the back end.
// Reset is asynchronous, active low; the display is blank and all digits off after it.
// A stalled rsp fills the two-entry queue, after which req drops ready.
`default_nettype none

module seven_segment_scan_driver import seg_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	seg_stream_if.sink    req,
	seg_stream_if.source  rsp
);

	localparam int ENTRY_W = SEG_BITS * DIGIT_COUNT + 1;

	seg_stream_if #(.payload_t(logic [ENTRY_W-1:0])) front_cmd ();
	seg_stream_if #(.payload_t(logic [ENTRY_W-1:0])) back_cmd ();

	seg_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (front_cmd)
	);

	seg_queue #(.WIDTH(ENTRY_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_cmd),
		.pop    (back_cmd)
	);

	seg_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (back_cmd),
		.rsp    (rsp)
	);

	// A latch result always closes a tick's run
	a_latch_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.latch_pulse |-> rsp.data.last)
		else $error("latch result not marked last");

	// Shift results never close a run and never latch
	a_shift_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.shift_pulse |-> !rsp.data.last && !rsp.data.latch_pulse)
		else $error("shift result marked last or latching");

	// Scanning keeps at most one digit driven
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0(rsp.data.digit_enables))
		else $error("more than one digit enabled");

endmodule

`default_nettype wire

// ===== verif/seg_scan_checker.sv =====
// Scoreboard for the seven-segment scan driver: watches the req and rsp channels,
// predicts each tick's shift and latch frames, and compares them field by field.
// Depends on seg_pkg for the item types and function codes.
`timescale 1ns / 1ps

module seg_scan_checker import seg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  in_item_t  req_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  out_item_t rsp_data,
	output int        fault_count,
	output int        frames_due
);

	localparam int DIGITS = 4;

	// Segment patterns for digits 0 to 9, point bit clear
	localparam logic [7:0] GLYPH [10] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
	};

	// Predicted display state
	logic [7:0] digit_pattern [DIGITS];
	logic       lit;
	int         scan_pos;
	int         prior_pos;
	logic       has_prior;
	logic [3:0] enables;

	// Frames still owed by the block, oldest first
	out_item_t  shift_frames [$];

	// Apply one accepted item to the predicted display and queue its frames
	task automatic advance_display(input in_item_t it);
		logic [31:0] v;
		logic [7:0]  pat;
		int          cur;
		if (it.func == FUNC_SET) begin
			v = it.scaled_value;
			for (int i = 0; i < DIGITS; i++) begin
				pat = GLYPH[v % 10];
				v = v / 10;
				if (it.decimals != 0 && it.decimals == i)
					pat = pat | POINT_BIT;
				digit_pattern[i] = pat;
			end
			lit = 1'b1;
		end else begin
			cur = scan_pos;
			// Shift the current digit out LSB first, then turn it on
			if (lit) begin
				pat = digit_pattern[cur];
				for (int b = 0; b < SEG_BITS; b++)
					shift_frames.push_back('{serial_data: pat[b], shift_pulse: 1'b1,
						latch_pulse: 1'b0, digit_enables: enables, last: 1'b0});
				enables = enables | (4'b0001 << cur);
			end
			// Drop the previously scanned digit
			if (has_prior && prior_pos != cur)
				enables = enables & ~(4'b0001 << prior_pos);
			shift_frames.push_back('{serial_data: 1'b0, shift_pulse: 1'b0,
				latch_pulse: lit, digit_enables: enables, last: 1'b1});
			prior_pos = cur;
			has_prior = 1'b1;
			scan_pos  = (cur == DIGITS - 1) ? 0 : cur + 1;
		end
	endtask

	task automatic report_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		fault_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			lit         = 1'b0;
			scan_pos    = 0;
			prior_pos   = 0;
			has_prior   = 1'b0;
			enables     = 4'b0000;
			fault_count = 0;
			for (int i = 0; i < DIGITS; i++)
				digit_pattern[i] = 8'h00;
			shift_frames.delete();
		end else begin
			// Compare a delivered frame with the oldest prediction
			if (rsp_valid && rsp_ready) begin
				if (shift_frames.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %b", $time,
						rsp_data);
					fault_count++;
				end else begin
					want = shift_frames.pop_front();
					if (rsp_data.serial_data !== want.serial_data)
						report_field("serial_data", want.serial_data, rsp_data.serial_data);
					if (rsp_data.shift_pulse !== want.shift_pulse)
						report_field("shift_pulse", want.shift_pulse, rsp_data.shift_pulse);
					if (rsp_data.latch_pulse !== want.latch_pulse)
						report_field("latch_pulse", want.latch_pulse, rsp_data.latch_pulse);
					if (rsp_data.digit_enables !== want.digit_enables)
						report_field("digit_enables", want.digit_enables,
							rsp_data.digit_enables);
					if (rsp_data.last !== want.last)
						report_field("last", want.last, rsp_data.last);
				end
			end
			// Predict from each accepted item
			if (req_valid && req_ready)
				advance_display(req_data);
		end
		frames_due = shift_frames.size();
	end

endmodule

// ===== verif/tb_seven_segment_scan_driver.sv =====
// Top of the scan driver testbench: clock, reset, item stimulus with idling phases
// and a long receiver hold-off, and the final verdict.
// Depends on seg_pkg, seg_stream_if, seven_segment_scan_driver and seg_scan_checker.
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver import seg_pkg::*; ();

	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 85;

	logic clk;
	logic arst_n;
	int   fault_count;
	int   frames_due;
	int   cycle_count;
	int   send_idle;
	int   stall_pct;
	bit   long_hold;

	seg_stream_if #(.payload_t(in_item_t))  req ();
	seg_stream_if #(.payload_t(out_item_t)) rsp ();

	seven_segment_scan_driver i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	seg_scan_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_data    (req.data),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_data    (rsp.data),
		.fault_count (fault_count),
		.frames_due  (frames_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stop a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: random stalls, or one long hold-off when asked
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one item after random idle cycles and hold it until accepted
	task automatic send(input logic func, input logic [31:0] value, input logic [2:0] dec);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= '{func: func, scaled_value: value, decimals: dec};
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every predicted frame has arrived
	task automatic quiesce();
		req.valid <= 1'b0;
		@(posedge clk);
		while (frames_due != 0)
			@(posedge clk);
	endtask

	// Mostly ticks over a random value, with sets of assorted magnitudes
	task automatic send_random();
		logic [31:0] value;
		if ($urandom_range(99) < 20) begin
			case ($urandom_range(3))
				0: value = $urandom;
				1: value = $urandom_range(9999);
				2: value = $urandom_range(99);
				default: value = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'd10000;
			endcase
			send(FUNC_SET, value, 3'($urandom_range(4)));
		end else begin
			send(FUNC_TICK, $urandom, 3'($urandom_range(7)));
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.data  <= '0;
		send_idle = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Blank display: first tick has no previous digit, second clears nothing lit
		send(FUNC_TICK, 32'hFFFF_FFFF, 3'd7);
		send(FUNC_TICK, 32'h0000_0000, 3'd0);
		// Value extremes; a decimals count of four shows no point
		send(FUNC_SET, 32'd0, 3'd0);
		send(FUNC_TICK, 32'd0, 3'd0);
		send(FUNC_SET, 32'hFFFF_FFFF, 3'd4);
		send(FUNC_TICK, 32'h1234_5678, 3'd5);
		send(FUNC_TICK, 32'd0, 3'd0);
		// Point on digit positions one to three in turn
		send(FUNC_SET, 32'd5678, 3'd1);
		send(FUNC_TICK, 32'd0, 3'd0);
		send(FUNC_SET, 32'd90123, 3'd2);
		send(FUNC_TICK, 32'd0, 3'd0);
		send(FUNC_SET, 32'd4321, 3'd3);
		// Walk every digit and wrap the scan
		repeat (6) send(FUNC_TICK, $urandom, 3'd0);
		send(FUNC_SET, 32'd9999, 3'd0);
		repeat (4) send(FUNC_TICK, $urandom, 3'd2);
		quiesce();

		// Random items under each idling mix
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 87; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 87; end
				default: begin send_idle = 36; stall_pct = 36; end
			endcase
			repeat (PHASE_ITEMS) send_random();
			quiesce();
		end

		// Hold the receiver off while ticks keep coming, so the block backs up
		send_idle = 0;
		stall_pct = 0;
		long_hold = 1'b1;
		send(FUNC_SET, $urandom, 3'($urandom_range(4)));
		repeat (30) send(FUNC_TICK, $urandom, 3'($urandom_range(7)));
		quiesce();

		repeat (40) @(posedge clk);
		if (fault_count == 0 && frames_due == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
